/* rtl/core/e2c_pkg.sv */
// ----------------------------------------------------------------------------
// e2c_pkg
// Shared widths, pipeline depth and division constants for the epoch to
// calendar date converter.
// ----------------------------------------------------------------------------
package e2c_pkg;

    localparam int NUM_STAGES = 10;

    localparam int EPOCH_W  = 32;
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int DAYS_W   = 16;   // whole days since the epoch, at most 49710
    localparam int SOD_W    = 17;   // second of the day, below 86400
    localparam int DOY_W    = 9;    // day of the year, below 366

    localparam int OUT_DATA_W = 40; // 38 field bits filled up to whole bytes

    typedef logic [NUM_STAGES-1:0] stage_vec_t;

    // 86400 = 128 * 675: shift off 7 bits, then divide by 675
    localparam int DAY_LO_W        = 7;
    localparam logic [9:0]  DAY_DIV  = 10'd675;
    localparam logic [24:0] DAY_RECIP = 25'd25451658;  // floor(2^34 / 675)
    localparam int          DAY_SHIFT = 34;

    // 4-year cycle counted from 1968-01-01
    localparam logic [10:0] CYC_DAYS   = 11'd1461;
    localparam logic [15:0] CYC_RECIP  = 16'd45933;    // floor(2^26 / 1461)
    localparam int          CYC_SHIFT  = 26;
    localparam logic [15:0] EPOCH_OFS  = 16'd731;      // 1968-01-01 to 1970-01-01
    localparam logic [15:0] SKIP_DAY   = 16'd47541;    // 2100-03-01, no Feb 29 that year
    localparam logic [11:0] BASE_YEAR  = 12'd1968;
    localparam logic [10:0] YEAR1_START = 11'd366;
    localparam logic [10:0] YEAR2_START = 11'd731;
    localparam logic [10:0] YEAR3_START = 11'd1096;

    localparam logic [11:0] HOUR_SECS   = 12'd3600;
    localparam logic [16:0] HOUR_RECIP  = 17'd74565;   // floor(2^28 / 3600)
    localparam int          HOUR_SHIFT  = 28;
    localparam logic [5:0]  MIN_SECS    = 6'd60;
    localparam logic [12:0] MIN_RECIP   = 13'd4369;    // floor(2^18 / 60)
    localparam int          MIN_SHIFT   = 18;

    localparam logic [DOY_W-1:0] MONTH_START [12] = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // First day of year of a month (index 0 is January)
    function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] idx,
                                                     input logic leap);
        logic [DOY_W-1:0] base;
        base = (idx < 4'd12) ? MONTH_START[idx] : '0;
        if (leap && idx >= 4'd2) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

/* rtl/core/e2c_date_path.sv */
// ----------------------------------------------------------------------------
// e2c_date_path
// Stages 4 to 10: whole-day count to year, month and day of month.
// ----------------------------------------------------------------------------
module e2c_date_path import e2c_pkg::*; (
    input  logic                aclk,
    input  stage_vec_t          adv,
    input  logic [DAYS_W-1:0]   days,
    output logic [YEAR_W-1:0]   year,
    output logic [MONTH_W-1:0]  month,
    output logic [DAY_W-1:0]    day
);

    // stage 4
    logic [15:0]        d2_s4_reg;
    // stage 5
    logic [15:0]        d2_s5_reg;
    logic [31:0]        prodc_reg;
    // stage 6
    logic [15:0]        d2_s6_reg;
    logic [5:0]         cest_reg;
    logic [15:0]        pc_reg;
    // stage 7
    logic [5:0]         cyc_reg;
    logic [10:0]        rc_reg;
    // stage 8
    logic [YEAR_W-1:0]  year_s8_reg;
    logic [DOY_W-1:0]   doy_s8_reg;
    logic               leap_s8_reg;
    // stage 9
    logic [YEAR_W-1:0]  year_s9_reg;
    logic [DOY_W-1:0]   doy_s9_reg;
    logic               leap_s9_reg;
    logic [MONTH_W-1:0] midx_reg;
    // stage 10
    logic [YEAR_W-1:0]  year_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [DAY_W-1:0]   day_reg;

    logic [15:0]        d2_next;
    logic [15:0]        diff;
    logic [5:0]         cyc_next;
    logic [10:0]        rc_next;
    logic [1:0]         yoff;
    logic [10:0]        ystart;
    logic [YEAR_W-1:0]  year_next;
    logic [DOY_W-1:0]   doy_next;
    logic [MONTH_W-1:0] midx_next;
    logic [DOY_W-1:0]   mstart;
    logic [DOY_W-1:0]   dom;

    always_comb begin
        // fake a Feb 29 in 2100 so the 4-year cycle holds to the end of range
        d2_next = days + EPOCH_OFS + ((days >= SKIP_DAY) ? 16'd1 : 16'd0);

        diff = d2_s6_reg - pc_reg;
        if (diff >= 16'(CYC_DAYS)) begin
            cyc_next = cest_reg + 6'd1;
            rc_next  = 11'(diff - 16'(CYC_DAYS));
        end else begin
            cyc_next = cest_reg;
            rc_next  = diff[10:0];
        end

        priority if (rc_reg < YEAR1_START) begin
            yoff   = 2'd0;
            ystart = 11'd0;
        end else if (rc_reg < YEAR2_START) begin
            yoff   = 2'd1;
            ystart = YEAR1_START;
        end else if (rc_reg < YEAR3_START) begin
            yoff   = 2'd2;
            ystart = YEAR2_START;
        end else begin
            yoff   = 2'd3;
            ystart = YEAR3_START;
        end
        doy_next  = DOY_W'(rc_reg - ystart);
        year_next = BASE_YEAR + {4'd0, cyc_reg, 2'b00} + {10'd0, yoff};

        // boundaries rise with the index: the last one passed wins
        midx_next = '0;
        for (int i = 1; i < 12; i++) begin
            if (doy_s8_reg >= month_start(MONTH_W'(i), leap_s8_reg)) begin
                midx_next = MONTH_W'(i);
            end
        end

        mstart = month_start(midx_reg, leap_s9_reg);
        dom    = doy_s9_reg - mstart + 9'd1;
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            d2_s4_reg <= d2_next;
        end
        if (adv[4]) begin
            d2_s5_reg <= d2_s4_reg;
            prodc_reg <= d2_s4_reg * CYC_RECIP;
        end
        if (adv[5]) begin
            d2_s6_reg <= d2_s5_reg;
            cest_reg  <= prodc_reg[CYC_SHIFT+5:CYC_SHIFT];
        end
        if (adv[6]) begin
            cyc_reg <= cyc_next;
            rc_reg  <= rc_next;
        end
        if (adv[7]) begin
            year_s8_reg <= year_next;
            doy_s8_reg  <= doy_next;
            leap_s8_reg <= (yoff == 2'd0);
        end
        if (adv[8]) begin
            year_s9_reg <= year_s8_reg;
            doy_s9_reg  <= doy_s8_reg;
            leap_s9_reg <= leap_s8_reg;
            midx_reg    <= midx_next;
        end
        if (adv[9]) begin
            year_reg  <= year_s9_reg;
            month_reg <= midx_reg + 4'd1;
            day_reg   <= dom[DAY_W-1:0];
        end
    end

    // pc is formed from the stage 6 estimate and lands with it
    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            pc_reg <= 16'(prodc_reg[CYC_SHIFT+5:CYC_SHIFT] * CYC_DAYS);
        end
    end

    assign year  = year_reg;
    assign month = month_reg;
    assign day   = day_reg;

endmodule

/* rtl/core/epoch_to_calendar_date_top.sv */
// ----------------------------------------------------------------------------
// epoch_to_calendar_date_top
// Unix seconds to Gregorian date and time of day, ten-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one 32-bit unsigned count of seconds since 1970-01-01.
//   m_tdata returns year, month, day, hour, minute and second for it.
//   Each word is taken on a rising aclk edge with tvalid and tready high.
// Flow: each accepted word moves through the stage registers in order,
//   and m_tvalid rises once it is held in the last stage.
// Throughput: one word per cycle unless stalled; every stage holds one word,
//   and divisions by 86400, 1461, 3600 and 60 are reciprocal multiplies
//   followed by one compare-and-subtract fix-up, each spread over three stages.
// Stalls: a stage loads whenever it is empty or the stage after it moves,
//   so bubbles close up and s_tready drops only when all ten stages are
//   full and m_tready is low. A held result keeps m_tdata stable.
// Reset: aresetn low at an edge empties the pipeline; no other state.
// Date math: days are counted in 4-year cycles from 1968-01-01; a virtual
//   Feb 29 is inserted in 2100 by skipping one day from 2100-03-01 on.
// ----------------------------------------------------------------------------
module epoch_to_calendar_date_top import e2c_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [EPOCH_W-1:0]    s_tdata,   // [31:0] epoch_seconds
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [11:0] year, [15:12] month,
                                             // [20:16] day, [25:21] hour,
                                             // [31:26] minute, [37:32] second,
                                             // [39:38] zero
);

    stage_vec_t valid_reg;
    stage_vec_t adv;

    // day split, stages 1 to 3
    logic [24:0]           q_s1_reg, q_s2_reg;
    logic [DAY_LO_W-1:0]   lo_s1_reg, lo_s2_reg, lo_s3_reg;
    logic [49:0]           prodd_reg;
    logic [DAYS_W-1:0]     dest_reg;
    logic [24:0]           pd_reg;
    logic [DAYS_W-1:0]     days_reg;
    logic [9:0]            rday_reg;
    logic [24:0]           rdiff;
    logic [DAYS_W-1:0]     days_next;
    logic [9:0]            rday_next;

    // time of day, stages 4 to 10
    logic [SOD_W-1:0]      sod_s4_reg, sod_s5_reg, sod_s6_reg;
    logic [33:0]           prodh_reg;
    logic [HOUR_W-1:0]     hest_reg;
    logic [16:0]           ph_reg;
    logic [HOUR_W-1:0]     hour_s7_reg, hour_s8_reg, hour_s9_reg, hour_reg;
    logic [11:0]           rh_s7_reg, rh_s8_reg, rh_s9_reg;
    logic [24:0]           prodm_reg;
    logic [MINUTE_W-1:0]   mest_reg;
    logic [11:0]           pm_reg;
    logic [MINUTE_W-1:0]   minute_reg;
    logic [SECOND_W-1:0]   second_reg;
    logic [16:0]           hdiff;
    logic [HOUR_W-1:0]     hour_next;
    logic [11:0]           rh_next;
    logic [11:0]           mdiff;
    logic [MINUTE_W-1:0]   minute_next;
    logic [SECOND_W-1:0]   second_next;

    logic [YEAR_W-1:0]     year;
    logic [MONTH_W-1:0]    month;
    logic [DAY_W-1:0]      day;

    // a stage loads when empty or when its successor moves
    always_comb begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign s_tready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (adv[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_comb begin
        // estimate is exact or one low; fix it with one subtract
        rdiff = q_s2_reg - pd_reg;
        if (rdiff >= 25'(DAY_DIV)) begin
            days_next = dest_reg + 16'd1;
            rday_next = 10'(rdiff - 25'(DAY_DIV));
        end else begin
            days_next = dest_reg;
            rday_next = rdiff[9:0];
        end

        hdiff = sod_s6_reg - ph_reg;
        if (hdiff >= 17'(HOUR_SECS)) begin
            hour_next = hest_reg + 5'd1;
            rh_next   = 12'(hdiff - 17'(HOUR_SECS));
        end else begin
            hour_next = hest_reg;
            rh_next   = hdiff[11:0];
        end

        mdiff = rh_s9_reg - pm_reg;
        if (mdiff >= 12'(MIN_SECS)) begin
            minute_next = mest_reg + 6'd1;
            second_next = 6'(mdiff - 12'(MIN_SECS));
        end else begin
            minute_next = mest_reg;
            second_next = mdiff[5:0];
        end
    end

    always_ff @(posedge aclk) begin
        // stage 1: drop the 7 low bits, multiply by the reciprocal of 675
        if (adv[0]) begin
            q_s1_reg  <= s_tdata[EPOCH_W-1:DAY_LO_W];
            lo_s1_reg <= s_tdata[DAY_LO_W-1:0];
            prodd_reg <= s_tdata[EPOCH_W-1:DAY_LO_W] * DAY_RECIP;
        end
        // stage 2: day estimate and its product back
        if (adv[1]) begin
            q_s2_reg  <= q_s1_reg;
            lo_s2_reg <= lo_s1_reg;
            dest_reg  <= prodd_reg[DAY_SHIFT+DAYS_W-1:DAY_SHIFT];
            pd_reg    <= 25'(prodd_reg[DAY_SHIFT+DAYS_W-1:DAY_SHIFT] * DAY_DIV);
        end
        // stage 3: corrected day count and remainder
        if (adv[2]) begin
            days_reg  <= days_next;
            rday_reg  <= rday_next;
            lo_s3_reg <= lo_s2_reg;
        end
        // stage 4: rebuild second of day
        if (adv[3]) begin
            sod_s4_reg <= {rday_reg, lo_s3_reg};
        end
        if (adv[4]) begin
            sod_s5_reg <= sod_s4_reg;
            prodh_reg  <= sod_s4_reg * HOUR_RECIP;
        end
        if (adv[5]) begin
            sod_s6_reg <= sod_s5_reg;
            hest_reg   <= prodh_reg[HOUR_SHIFT+HOUR_W-1:HOUR_SHIFT];
            ph_reg     <= 17'(prodh_reg[HOUR_SHIFT+HOUR_W-1:HOUR_SHIFT] * HOUR_SECS);
        end
        if (adv[6]) begin
            hour_s7_reg <= hour_next;
            rh_s7_reg   <= rh_next;
        end
        if (adv[7]) begin
            hour_s8_reg <= hour_s7_reg;
            rh_s8_reg   <= rh_s7_reg;
            prodm_reg   <= rh_s7_reg * MIN_RECIP;
        end
        if (adv[8]) begin
            hour_s9_reg <= hour_s8_reg;
            rh_s9_reg   <= rh_s8_reg;
            mest_reg    <= prodm_reg[MIN_SHIFT+MINUTE_W-1:MIN_SHIFT];
            pm_reg      <= 12'(prodm_reg[MIN_SHIFT+MINUTE_W-1:MIN_SHIFT] * MIN_SECS);
        end
        if (adv[9]) begin
            hour_reg   <= hour_s9_reg;
            minute_reg <= minute_next;
            second_reg <= second_next;
        end
    end

    e2c_date_path u_date (
        .aclk  (aclk),
        .adv   (adv),
        .days  (days_reg),
        .year  (year),
        .month (month),
        .day   (day)
    );

    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = {2'b00, second_reg, minute_reg, hour_reg, day, month, year};

endmodule

/* rtl/core/e2c_checker.sv */
// ----------------------------------------------------------------------------
// e2c_checker
// Port-level checks on the converter's result channel.
// ----------------------------------------------------------------------------
module e2c_checker import e2c_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // pipeline is empty right after a reset edge
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a held result keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // input may stall only when a full result is being held
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with room in the pipeline");

    // every delivered date and time lies in range; the day is checked only against its lower bound
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[11:0] >= 12'd1970 && m_tdata[11:0] <= 12'd2106
                  && m_tdata[15:12] >= 4'd1 && m_tdata[15:12] <= 4'd12
                  && m_tdata[20:16] >= 5'd1 && m_tdata[25:21] <= 5'd23
                  && m_tdata[31:26] <= 6'd59 && m_tdata[37:32] <= 6'd59)
        else $error("result field out of range");

endmodule

bind epoch_to_calendar_date_top e2c_checker u_e2c_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
